### rtl/mlr_pkg.sv
// ============================================================================
// mlr_pkg
// Shared types, widths and octant mapping functions for the midpoint line
// rasteriser.
// ============================================================================
package mlr_pkg;

   // Coordinate width of endpoints and emitted pixels
   localparam int COORD_BITS = 12;
   // Octant-0 walk coordinates need one more bit (negated most negative value)
   localparam int WALK_BITS  = COORD_BITS + 1;
   // Decision variable and its increments
   localparam int DEC_BITS   = COORD_BITS + 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [WALK_BITS-1:0]  walk_type;
   typedef logic signed [DEC_BITS-1:0]   dec_type;

   // Transaction kinds on the request channel
   typedef enum logic {
      REQ_START = 1'b0,
      REQ_STEP  = 1'b1
   } req_kind_type;

   // Octants, counted anticlockwise from the shallow positive one
   typedef enum logic [2:0] {
      OCT0 = 3'd0,
      OCT1 = 3'd1,
      OCT2 = 3'd2,
      OCT3 = 3'd3,
      OCT4 = 3'd4,
      OCT5 = 3'd5,
      OCT6 = 3'd6,
      OCT7 = 3'd7
   } octant_type;

   typedef struct packed {
      walk_type a;
      walk_type b;
   } point_type;

   // Everything the start transaction loads into the walker
   typedef struct packed {
      octant_type octant;
      walk_type   walk_x;
      walk_type   walk_y;
      walk_type   stop_x;
      dec_type    decision;
      dec_type    east_inc;
      dec_type    diag_inc;
      logic       last;
   } setup_type;

   // Map a point of the given octant into octant 0
   function automatic point_type to_oct0(octant_type oct, walk_type x, walk_type y);
      point_type p;
      case (oct)
         OCT0:    begin p.a = x;  p.b = y;  end
         OCT1:    begin p.a = y;  p.b = x;  end
         OCT2:    begin p.a = y;  p.b = -x; end
         OCT3:    begin p.a = -x; p.b = y;  end
         OCT4:    begin p.a = -x; p.b = -y; end
         OCT5:    begin p.a = -y; p.b = -x; end
         OCT6:    begin p.a = -y; p.b = x;  end
         default: begin p.a = x;  p.b = -y; end
      endcase
      return p;
   endfunction

   // Map an octant-0 point back into the given octant
   function automatic point_type from_oct0(octant_type oct, walk_type u, walk_type v);
      point_type p;
      case (oct)
         OCT0:    begin p.a = u;  p.b = v;  end
         OCT1:    begin p.a = v;  p.b = u;  end
         OCT2:    begin p.a = -v; p.b = u;  end
         OCT3:    begin p.a = -u; p.b = v;  end
         OCT4:    begin p.a = -u; p.b = -v; end
         OCT5:    begin p.a = -v; p.b = -u; end
         OCT6:    begin p.a = v;  p.b = -u; end
         default: begin p.a = u;  p.b = -v; end
      endcase
      return p;
   endfunction

   // Magnitude of a signed difference
   function automatic logic [WALK_BITS-1:0] mag(walk_type v);
      return v[WALK_BITS-1] ? WALK_BITS'(-v) : WALK_BITS'(v);
   endfunction

endpackage

### rtl/mlr_if.sv
// ============================================================================
// mlr_req_if / mlr_rsp_if
// Valid/ready channels of the rasteriser: endpoint and step requests in,
// pixels out.
// ============================================================================
interface mlr_req_if;
   import mlr_pkg::*;

   logic      valid;
   logic      ready;
   logic      req_type;
   coord_type x_start;
   coord_type y_start;
   coord_type x_end;
   coord_type y_end;

   modport source (output valid, req_type, x_start, y_start, x_end, y_end,
                   input ready);
   modport sink   (input valid, req_type, x_start, y_start, x_end, y_end,
                   output ready);
endinterface

interface mlr_rsp_if;
   import mlr_pkg::*;

   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   logic      pixel_valid;
   logic      last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_valid, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_pixel,
                   output ready);
endinterface

### rtl/mlr_setup.sv
// ============================================================================
// mlr_setup
// Line setup: picks the octant, folds both endpoints into octant 0 and
// derives the midpoint decision variable and its increments.
// ============================================================================
module mlr_setup (
   input  mlr_pkg::coord_type x_start,
   input  mlr_pkg::coord_type y_start,
   input  mlr_pkg::coord_type x_end,
   input  mlr_pkg::coord_type y_end,
   output mlr_pkg::setup_type setup
);
   import mlr_pkg::*;

   walk_type   x1, y1, x2, y2;
   walk_type   dx, dy;
   logic       flat;
   octant_type oct;
   point_type  p1, p2;
   walk_type   ddx, ddy;
   dec_type    ddx_w, ddy_w;

   // Endpoint deltas in the wider walk format
   assign x1   = WALK_BITS'(x_start);
   assign y1   = WALK_BITS'(y_start);
   assign x2   = WALK_BITS'(x_end);
   assign y2   = WALK_BITS'(y_end);
   assign dx   = x2 - x1;
   assign dy   = y2 - y1;
   assign flat = mag(dx) > mag(dy);

   // Octant choice; equal magnitudes fall to the steep octant
   always_comb begin
      if (!dx[WALK_BITS-1] && !dy[WALK_BITS-1]) begin
         oct = flat ? OCT0 : OCT1;
      end else if (!dx[WALK_BITS-1]) begin
         oct = flat ? OCT7 : OCT6;
      end else if (dy[WALK_BITS-1]) begin
         oct = flat ? OCT4 : OCT5;
      end else begin
         oct = flat ? OCT3 : OCT2;
      end
   end

   // Fold into octant 0 and load the decision terms
   assign p1    = to_oct0(oct, x1, y1);
   assign p2    = to_oct0(oct, x2, y2);
   assign ddx   = p2.a - p1.a;
   assign ddy   = p2.b - p1.b;
   assign ddx_w = DEC_BITS'(ddx);
   assign ddy_w = DEC_BITS'(ddy);

   assign setup.octant   = oct;
   assign setup.walk_x   = p1.a;
   assign setup.walk_y   = p1.b;
   assign setup.stop_x   = p2.a;
   assign setup.decision = (ddy_w + ddy_w) - ddx_w;
   assign setup.east_inc = ddy_w + ddy_w;
   assign setup.diag_inc = (ddy_w - ddx_w) + (ddy_w - ddx_w);
   assign setup.last     = p1.a >= p2.a;

endmodule

### rtl/midpoint_line_rasterizer.sv
// ============================================================================
// midpoint_line_rasterizer
// Eight-octant midpoint line walker: a start transaction loads a line and
// returns its first pixel; a step on the active line returns the next pixel.
// ============================================================================
//
//   Channel  Dir  Handshake     Payload
//   req_chan in   valid/ready   req_type, x_start, y_start, x_end, y_end
//   rsp_chan out  valid/ready   pixel_x, pixel_y, pixel_valid, last_pixel
//
// One transaction per clock while the output is not stalled. A request is
// captured in the input register; its pixel is computed and the walker state
// updated as it moves into the output register, which presents the pixel.
// Reset is synchronous and clears the walker state, including the line-active
// flag, and both valid bits.
// A stalled output holds both stages; the input register still takes a
// transaction whenever it is empty.
// ============================================================================
module midpoint_line_rasterizer (
   input logic        clock,
   input logic        reset,
   mlr_req_if.sink    req_chan,
   mlr_rsp_if.source  rsp_chan
);
   import mlr_pkg::*;

   // Input register
   logic         in_valid_ff;
   req_kind_type in_type_ff;
   coord_type    in_x_start_ff, in_y_start_ff, in_x_end_ff, in_y_end_ff;

   // Walker state
   walk_type   walk_x_ff, walk_x_in;
   walk_type   walk_y_ff, walk_y_in;
   walk_type   stop_x_ff, stop_x_in;
   dec_type    decision_ff, decision_in;
   dec_type    east_inc_ff, east_inc_in;
   dec_type    diag_inc_ff, diag_inc_in;
   octant_type octant_ff, octant_in;
   logic       line_active_ff, line_active_in;

   // Output register
   logic       rsp_valid_ff;
   coord_type  pixel_x_ff, pixel_x_in;
   coord_type  pixel_y_ff, pixel_y_in;
   logic       pixel_valid_ff, pixel_valid_in;
   logic       last_pixel_ff, last_pixel_in;

   logic       advance, fire;
   setup_type  setup;
   walk_type   step_x, step_y;
   point_type  step_pt;

   // Handshake: stage moves when the output slot is free or being taken
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_type_ff    <= req_kind_type'(req_chan.req_type);
         in_x_start_ff <= req_chan.x_start;
         in_y_start_ff <= req_chan.y_start;
         in_x_end_ff   <= req_chan.x_end;
         in_y_end_ff   <= req_chan.y_end;
      end
   end

   // Line setup for start transactions
   mlr_setup u_setup (
      .x_start (in_x_start_ff),
      .y_start (in_y_start_ff),
      .x_end   (in_x_end_ff),
      .y_end   (in_y_end_ff),
      .setup   (setup)
   );

   // One midpoint step and the unfold back to the line's octant
   assign step_x  = walk_x_ff + WALK_BITS'(1);
   assign step_y  = decision_ff[DEC_BITS-1] ? walk_y_ff : walk_y_ff + WALK_BITS'(1);
   assign step_pt = from_oct0(octant_ff, step_x, step_y);

   // Next walker state and pixel
   always_comb begin
      walk_x_in      = walk_x_ff;
      walk_y_in      = walk_y_ff;
      stop_x_in      = stop_x_ff;
      decision_in    = decision_ff;
      east_inc_in    = east_inc_ff;
      diag_inc_in    = diag_inc_ff;
      octant_in      = octant_ff;
      line_active_in = line_active_ff;
      pixel_x_in     = '0;
      pixel_y_in     = '0;
      pixel_valid_in = 1'b0;
      last_pixel_in  = 1'b0;
      case (in_type_ff)
         REQ_START: begin
            walk_x_in      = setup.walk_x;
            walk_y_in      = setup.walk_y;
            stop_x_in      = setup.stop_x;
            decision_in    = setup.decision;
            east_inc_in    = setup.east_inc;
            diag_inc_in    = setup.diag_inc;
            octant_in      = setup.octant;
            line_active_in = !setup.last;
            pixel_x_in     = in_x_start_ff;
            pixel_y_in     = in_y_start_ff;
            pixel_valid_in = 1'b1;
            last_pixel_in  = setup.last;
         end
         REQ_STEP: begin
            if (line_active_ff) begin
               walk_x_in      = step_x;
               walk_y_in      = step_y;
               decision_in    = decision_ff[DEC_BITS-1] ? decision_ff + east_inc_ff
                                                        : decision_ff + diag_inc_ff;
               line_active_in = !(step_x >= stop_x_ff);
               pixel_x_in     = step_pt.a[COORD_BITS-1:0];
               pixel_y_in     = step_pt.b[COORD_BITS-1:0];
               pixel_valid_in = 1'b1;
               last_pixel_in  = step_x >= stop_x_ff;
            end
         end
         default: begin
            line_active_in = line_active_ff;
         end
      endcase
   end

   // Walker state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff      <= '0;
         walk_y_ff      <= '0;
         stop_x_ff      <= '0;
         decision_ff    <= '0;
         east_inc_ff    <= '0;
         diag_inc_ff    <= '0;
         octant_ff      <= OCT0;
         line_active_ff <= 1'b0;
      end else if (fire) begin
         walk_x_ff      <= walk_x_in;
         walk_y_ff      <= walk_y_in;
         stop_x_ff      <= stop_x_in;
         decision_ff    <= decision_in;
         east_inc_ff    <= east_inc_in;
         diag_inc_ff    <= diag_inc_in;
         octant_ff      <= octant_in;
         line_active_ff <= line_active_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pixel_x_ff     <= pixel_x_in;
         pixel_y_ff     <= pixel_y_in;
         pixel_valid_ff <= pixel_valid_in;
         last_pixel_ff  <= last_pixel_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = pixel_x_ff;
   assign rsp_chan.pixel_y     = pixel_y_ff;
   assign rsp_chan.pixel_valid = pixel_valid_ff;
   assign rsp_chan.last_pixel  = last_pixel_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // An idle step returns an all-zero transaction
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !pixel_valid_ff |->
         pixel_x_ff == '0 && pixel_y_ff == '0 && !last_pixel_ff)
      else $error("idle step result carries non-zero payload");

   // An active line has not yet reached its end x
   a_active_before_stop: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> walk_x_ff < stop_x_ff)
      else $error("line active at or beyond its end point");

   // Emitting the last pixel ends the line
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      fire && last_pixel_in |=> !line_active_ff)
      else $error("line still active after its last pixel");

   // A step on an active line moves x by exactly one
   a_step_advances_x: assert property (@(posedge clock) disable iff (reset)
      fire && in_type_ff == REQ_STEP && line_active_ff |=>
         walk_x_ff == $past(walk_x_ff) + WALK_BITS'(1))
      else $error("step did not advance x by one");

endmodule
